// ===== hw/rtl/assert_macros.svh =====
// Assertion helpers used by the RTL. Both expect clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define TCCA_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`define TCCA_ASSERT_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`else

`define TCCA_ASSERT(lbl, prop, msg)

`define TCCA_ASSERT_NEVER(lbl, cond, msg)

`endif

`endif

// ===== hw/rtl/tcca_pkg.sv =====
// ----------------------------------------------------------------------------
// tcca_pkg
// Types, command codes and helpers for the one-dimensional totalistic ring.
// ----------------------------------------------------------------------------
`default_nettype none

package tcca_pkg;

    localparam int CELLS_DEF = 256;

    // Width used to compare a cell position against a request index.
    localparam int IDX_CMP_W = 11;

    localparam logic [1:0] CMD_LOAD = 2'd0;
    localparam logic [1:0] CMD_STEP = 2'd1;
    localparam logic [1:0] CMD_READ = 2'd2;

    localparam logic [2:0] CELL_MAX = 3'd4;
    localparam logic [9:0] SUM_MAX  = 10'd1023;

    typedef struct packed {
        logic [1:0] cmd;
        logic [7:0] cell_index;
        logic [2:0] cell_value;
    } req_t;

    typedef struct packed {
        logic [9:0]  row_sum;
        logic [31:0] step_count;
        logic [2:0]  read_value;
    } rsp_t;

    typedef struct packed {
        logic       load;
        logic       step;
        logic       shift;
        logic [7:0] index;
        logic [2:0] value;
    } cell_ctrl_t;

    // Sum of three cells (at most 12) reduced modulo five.
    function automatic logic [2:0] mod5(input logic [3:0] s);
        logic [3:0] r;
        if (s >= 4'd10)
        begin
            r = s - 4'd10;
        end
        else if (s >= 4'd5)
        begin
            r = s - 4'd5;
        end
        else
        begin
            r = s;
        end
        return r[2:0];
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/tcca_cell.sv =====
// ----------------------------------------------------------------------------
// tcca_cell
// One ring position: holds a value 0 to 4, takes loads addressed to it,
// applies the totalistic rule, and passes its value down the ring on a scan.
// ----------------------------------------------------------------------------
`default_nettype none

module tcca_cell #(
    parameter int INDEX = 0
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire tcca_pkg::cell_ctrl_t ctrl,
    input  wire logic [2:0]          left,
    input  wire logic [2:0]          right,
    output logic [2:0]               value
);

    logic [2:0] value_reg;
    logic [2:0] value_next;
    logic       hit;

    assign hit = (tcca_pkg::IDX_CMP_W'(ctrl.index) == tcca_pkg::IDX_CMP_W'(INDEX));

    always_comb
    begin
        value_next = value_reg;
        if (ctrl.load && hit)
        begin
            value_next = ctrl.value;
        end
        else if (ctrl.step)
        begin
            value_next = tcca_pkg::mod5({1'b0, left} + {1'b0, value_reg} + {1'b0, right});
        end
        else if (ctrl.shift)
        begin
            value_next = right;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            value_reg <= '0;
        end
        else
        begin
            value_reg <= value_next;
        end
    end

    assign value = value_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/totalistic_cellular_automaton_1d.sv =====
// ----------------------------------------------------------------------------
// totalistic_cellular_automaton_1d
// Ring of CELLS cells under the rule (left + self + right) mod 5.
// ----------------------------------------------------------------------------
// A load returns no item. A step or a read returns one result item, built in
// the scan and done states after acceptance: the step itself is one parallel
// update of all cells, and the row sum (and the read value) come from
// rotating the whole ring once past cell zero, one position per cycle,
// which leaves the row as it was. The next request is accepted once the
// result has been placed in the output register, even if it is still waiting
// to be taken. All cells reset to zero, so no clearing pass follows reset.
`default_nettype none

module totalistic_cellular_automaton_1d #(
    parameter int CELLS = tcca_pkg::CELLS_DEF
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           req_valid,
    output logic                req_ready,
    input  wire tcca_pkg::req_t req,
    output logic                rsp_valid,
    input  wire logic           rsp_ready,
    output tcca_pkg::rsp_t      rsp
);

    localparam int CNT_W     = $clog2(CELLS);
    localparam int ACC_W     = $clog2(CELLS * 4 + 1);
    localparam int SUM_CMP_W = (ACC_W > 10) ? ACC_W : 10;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    logic [1:0]       state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [ACC_W-1:0] acc_reg, acc_next;
    logic [31:0]      gen_reg, gen_next;
    logic             is_read_reg, is_read_next;
    logic [7:0]       idx_reg, idx_next;
    logic [2:0]       rv_reg, rv_next;
    logic             rsp_valid_reg, rsp_valid_next;
    tcca_pkg::rsp_t   rsp_reg, rsp_next;

    logic             accept;
    logic             step_accept;
    logic             load_accept;
    logic             last;
    logic [9:0]       sum_sat;
    tcca_pkg::cell_ctrl_t ctrl;
    logic [2:0]       cell_val [CELLS];

    assign req_ready   = (state_reg == ST_IDLE);
    assign accept      = req_valid && req_ready;
    assign step_accept = accept && (req.cmd == tcca_pkg::CMD_STEP);
    assign load_accept = accept && (req.cmd == tcca_pkg::CMD_LOAD);
    assign last        = (cnt_reg == CNT_W'(CELLS - 1));

    always_comb
    begin
        ctrl.load  = accept && (req.cmd == tcca_pkg::CMD_LOAD);
        ctrl.step  = accept && (req.cmd == tcca_pkg::CMD_STEP);
        ctrl.shift = (state_reg == ST_SCAN);
        ctrl.index = req.cell_index;
        ctrl.value = (req.cell_value > tcca_pkg::CELL_MAX) ? tcca_pkg::CELL_MAX
                                                           : req.cell_value;
    end

    genvar k;
    generate
        for (k = 0; k < CELLS; k++)
        begin : g_cell
            localparam int LFT = (k == 0) ? CELLS - 1 : k - 1;
            localparam int RGT = (k == CELLS - 1) ? 0 : k + 1;
            tcca_cell #(
                .INDEX (k)
            ) u_cell (
                .clk   (clk),
                .rst_n (rst_n),
                .ctrl  (ctrl),
                .left  (cell_val[LFT]),
                .right (cell_val[RGT]),
                .value (cell_val[k])
            );
        end
    endgenerate

    assign sum_sat = (SUM_CMP_W'(acc_reg) > SUM_CMP_W'(tcca_pkg::SUM_MAX))
                   ? tcca_pkg::SUM_MAX : 10'(acc_reg);

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        acc_next       = acc_reg;
        gen_next       = gen_reg;
        is_read_next   = is_read_reg;
        idx_next       = idx_reg;
        rv_next        = rv_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && (req.cmd == tcca_pkg::CMD_STEP || req.cmd == tcca_pkg::CMD_READ))
                begin
                    state_next   = ST_SCAN;
                    cnt_next     = '0;
                    acc_next     = '0;
                    rv_next      = '0;
                    is_read_next = (req.cmd == tcca_pkg::CMD_READ);
                    idx_next     = req.cell_index;
                    if (req.cmd == tcca_pkg::CMD_STEP)
                    begin
                        gen_next = gen_reg + 32'd1;
                    end
                end
            end
            ST_SCAN:
            begin
                // Cell zero holds the original cell cnt_reg during this cycle.
                acc_next = acc_reg + ACC_W'(cell_val[0]);
                if (is_read_reg &&
                    (tcca_pkg::IDX_CMP_W'(cnt_reg) == tcca_pkg::IDX_CMP_W'(idx_reg)))
                begin
                    rv_next = cell_val[0];
                end
                cnt_next = cnt_reg + CNT_W'(1);
                if (last)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    rsp_next.row_sum    = sum_sat;
                    rsp_next.step_count = gen_reg;
                    rsp_next.read_value = rv_reg;
                    rsp_valid_next      = 1'b1;
                    state_next          = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            gen_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            gen_reg       <= gen_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg     <= cnt_next;
        acc_reg     <= acc_next;
        is_read_reg <= is_read_next;
        idx_reg     <= idx_next;
        rv_reg      <= rv_next;
        rsp_reg     <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

`include "assert_macros.svh"

    `TCCA_ASSERT(a_step_counts, step_accept |=> (gen_reg == $past(gen_reg) + 32'd1), "step count")
    `TCCA_ASSERT(a_load_keeps_count, load_accept |=> $stable(gen_reg), "load changed the count")
    `TCCA_ASSERT(a_rsp_from_done, $rose(rsp_valid_reg) |-> ($past(state_reg) == ST_DONE), "early item")
    `TCCA_ASSERT_NEVER(a_scan_no_accept, (state_reg == ST_SCAN) && req_ready, "accept during scan")

endmodule

`default_nettype wire
